// ===== hdl/bspq_pkg.sv =====
// Shared types, sizes and ordering function for the bounded sorted priority queue.
package bspq_pkg;

    localparam int DEPTH     = 16;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int POS_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CFG_W     = 5;
    localparam int IDX_W     = 16;
    localparam int VAL_W     = 32;
    localparam int APB_W     = 32;
    localparam int ADDR_W    = 1;

    localparam logic [ADDR_W-1:0] REG_MAX_ENTRIES = 1'b0;
    localparam logic [CFG_W-1:0]  MAX_ENTRIES_RST = CFG_W'(16);

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_CLR = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] val;
    } t_entry;

    typedef struct packed {
        t_op                     op;
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] entry_value;
    } t_in;

    typedef struct packed {
        t_status                 status;
        logic [CFG_W-1:0]        count;
        logic                    is_empty;
        logic                    is_full;
        logic [IDX_W-1:0]        min_index;
        logic signed [VAL_W-1:0] min_value;
        logic [IDX_W-1:0]        max_index;
        logic signed [VAL_W-1:0] max_value;
    } t_out;

    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctl;

    // true when a orders strictly below b: by value, then by index
    function automatic logic entry_before(input t_entry a, input t_entry b);
        logic lt_val;
        logic eq_val;
        lt_val = $signed(a.val) < $signed(b.val);
        eq_val = a.val == b.val;
        return lt_val || (eq_val && (a.idx < b.idx));
    endfunction

endpackage

// ===== hdl/bspq_cell.sv =====
// One storage cell of the sorted chain: holds an entry, shifts toward either neighbor.
module bspq_cell (
    input  logic                i_clk,
    input  bspq_pkg::t_cell_ctl i_ctl,
    input  bspq_pkg::t_entry    i_new,
    input  bspq_pkg::t_entry    i_left,
    input  bspq_pkg::t_entry    i_right,
    input  logic                i_occupied,
    input  logic                i_left_place,
    output bspq_pkg::t_entry    o_entry,
    output logic                o_before,
    output logic                o_place
);
    import bspq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    assign o_before = entry_before(i_new, r_entry);
    assign o_place  = !i_occupied || o_before;
    assign o_entry  = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.enq) begin
            if (i_left_place) begin
                n_entry = i_left;
            end else if (o_place) begin
                n_entry = i_new;
            end
        end else if (i_ctl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== hdl/bounded_sorted_priority_queue_top.sv =====
// Bounded sorted priority queue: a chain of entry cells, control, APB register and result port.
//
// Takes one command per clock: busy stays low, so start may be high in every cycle. The result
// of a command appears on o_result with o_done high in the cycle right after the transfer and
// holds there for that one cycle only. Enqueue and dequeue update every cell at once, since
// each cell compares the new entry with its own and shifts toward a neighbor in parallel;
// clear only zeroes the count. No clearing pass follows reset. max_entries sits at address 0.
module bounded_sorted_priority_queue_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  bspq_pkg::t_in                       i_cmd,
    output logic                                o_done,
    output bspq_pkg::t_out                      o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bspq_pkg::ADDR_W-1:0]         paddr,
    input  logic [bspq_pkg::APB_W-1:0]          pwdata,
    output logic [bspq_pkg::APB_W-1:0]          prdata,
    output logic                                pready
);
    import bspq_pkg::*;

    logic [CFG_W-1:0] r_max_entries;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_status          r_status;
    t_status          n_status;
    logic             r_done;

    logic             w_accept;
    logic [CNT_W-1:0] w_cap;
    logic             w_full;
    logic             w_any_before;
    t_cell_ctl        w_ctl;
    t_entry           w_new;
    t_entry           w_entry [DEPTH];
    logic [DEPTH-1:0] w_occ;
    logic [DEPTH-1:0] w_before;
    logic [DEPTH-1:0] w_place;
    logic [POS_W-1:0] w_last;
    logic             w_sort_bad;

    assign busy     = 1'b0;
    assign pready   = 1'b1;
    assign w_accept = start && !busy;
    assign w_new.idx = i_cmd.entry_index;
    assign w_new.val = i_cmd.entry_value;

    assign w_cap = (32'(r_max_entries) < 32'(DEPTH)) ? CNT_W'(r_max_entries) : CNT_W'(DEPTH);
    assign w_full       = r_count >= w_cap;
    assign w_any_before = |(w_before & w_occ);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_entry w_left;
            t_entry w_right;
            logic   w_left_place;

            assign w_occ[g] = r_count > CNT_W'(g);

            if (g == 0) begin : g_first
                assign w_left       = w_entry[g];
                assign w_left_place = 1'b0;
            end else begin : g_mid
                assign w_left       = w_entry[g-1];
                assign w_left_place = w_place[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign w_right = w_entry[g];
            end else begin : g_inner
                assign w_right = w_entry[g+1];
            end

            bspq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_new        (w_new),
                .i_left       (w_left),
                .i_right      (w_right),
                .i_occupied   (w_occ[g]),
                .i_left_place (w_left_place),
                .o_entry      (w_entry[g]),
                .o_before     (w_before[g]),
                .o_place      (w_place[g])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        w_ctl    = '0;
        if (w_accept) begin
            case (i_cmd.op)
                OP_ENQ: begin
                    if (w_cap == '0 || (w_full && !w_any_before)) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.enq = 1'b1;
                        if (!w_full) begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                end
                OP_DEQ: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_ctl.deq = 1'b1;
                        n_count   = r_count - CNT_W'(1);
                    end
                end
                OP_CLR: begin
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_status      <= ST_OK;
            r_done        <= 1'b0;
            r_max_entries <= MAX_ENTRIES_RST;
        end else begin
            r_count  <= n_count;
            r_status <= n_status;
            r_done   <= w_accept;
            if (psel && penable && pwrite && pready && paddr == REG_MAX_ENTRIES) begin
                r_max_entries <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr == REG_MAX_ENTRIES) ? APB_W'(r_max_entries) : '0;

    assign w_last = POS_W'(r_count - CNT_W'(1));

    always_comb begin
        o_result.status   = r_status;
        o_result.count    = CFG_W'(r_count);
        o_result.is_empty = r_count == '0;
        o_result.is_full  = w_full;
        if (r_count != '0) begin
            o_result.min_index = w_entry[0].idx;
            o_result.min_value = w_entry[0].val;
            o_result.max_index = w_entry[w_last].idx;
            o_result.max_value = w_entry[w_last].val;
        end else begin
            o_result.min_index = '0;
            o_result.min_value = '0;
            o_result.max_index = '0;
            o_result.max_value = '0;
        end
    end

    assign o_done = r_done;

    always_comb begin
        w_sort_bad = 1'b0;
        for (int i = 0; i < DEPTH - 1; i++) begin
            if (w_occ[i+1] && entry_before(w_entry[i+1], w_entry[i])) begin
                w_sort_bad = 1'b1;
            end
        end
    end

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("result strobe missing after transfer");

    a_reject_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |-> r_count == $past(r_count))
        else $error("count changed on rejected command");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_sort_bad)
        else $error("stored entries out of order");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count beyond built depth");

endmodule

// ===== bench/bspq_checker.sv =====
// Checker for the bounded sorted priority queue: tracks the queue, predicts each result and compares.
module bspq_checker
    import bspq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  t_in               i_cmd,
    input  logic              i_done,
    input  t_out              i_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    input  logic              pready,
    output int                o_fail_count,
    output int                o_pending
);

    t_entry           kept[DEPTH];
    int unsigned      kept_n;
    logic [CFG_W-1:0] max_entries_q;
    t_out             queue_views[$];
    int               fails;

    function automatic int unsigned capacity();
        return (max_entries_q < DEPTH) ? int'(max_entries_q) : DEPTH;
    endfunction

    function automatic logic ranks_below(input t_entry a, input t_entry b);
        if (a.val != b.val) return $signed(a.val) < $signed(b.val);
        return a.idx < b.idx;
    endfunction

    function automatic t_status insert_entry(input t_entry e);
        int unsigned cap;
        int unsigned pos;
        int unsigned last;
        logic        full;
        cap = capacity();
        if (cap == 0) return ST_FULL;
        full = kept_n >= cap;
        if (full && !ranks_below(e, kept[kept_n-1])) return ST_FULL;
        pos = 0;
        while (pos < kept_n && !ranks_below(e, kept[pos])) pos++;
        last = full ? kept_n - 1 : kept_n;
        for (int unsigned i = last; i > pos; i--) kept[i] = kept[i-1];
        kept[pos] = e;
        if (!full) kept_n++;
        return ST_OK;
    endfunction

    function automatic t_status remove_min();
        if (kept_n == 0) return ST_EMPTY;
        for (int unsigned i = 0; i + 1 < kept_n; i++) kept[i] = kept[i+1];
        kept_n--;
        return ST_OK;
    endfunction

    function automatic t_out queue_view(input t_status st);
        t_out r;
        r = '0;
        r.status   = st;
        r.count    = CFG_W'(kept_n);
        r.is_empty = (kept_n == 0);
        r.is_full  = (kept_n >= capacity());
        if (kept_n != 0) begin
            r.min_index = kept[0].idx;
            r.min_value = kept[0].val;
            r.max_index = kept[kept_n-1].idx;
            r.max_value = kept[kept_n-1].val;
        end
        return r;
    endfunction

    function automatic string show(input t_out r);
        return $sformatf("status=%0d count=%0d empty=%b full=%b min=(%0d,%0d) max=(%0d,%0d)",
                         r.status, r.count, r.is_empty, r.is_full,
                         r.min_index, r.min_value, r.max_index, r.max_value);
    endfunction

    always @(posedge i_clk) begin
        t_out    want;
        t_entry  e;
        t_status st;
        string   bad;
        if (!i_rst_n) begin
            kept_n        = 0;
            max_entries_q = MAX_ENTRIES_RST;
            fails         = 0;
            queue_views.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_MAX_ENTRIES)
                max_entries_q = pwdata[CFG_W-1:0];

            if (i_done) begin
                if (queue_views.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result with none pending: %s", $time, show(i_result));
                end else begin
                    want = queue_views.pop_front();
                    bad  = "";
                    if (i_result.status    !== want.status)    bad = {bad, " status"};
                    if (i_result.count     !== want.count)     bad = {bad, " count"};
                    if (i_result.is_empty  !== want.is_empty)  bad = {bad, " is_empty"};
                    if (i_result.is_full   !== want.is_full)   bad = {bad, " is_full"};
                    if (i_result.min_index !== want.min_index) bad = {bad, " min_index"};
                    if (i_result.min_value !== want.min_value) bad = {bad, " min_value"};
                    if (i_result.max_index !== want.max_index) bad = {bad, " max_index"};
                    if (i_result.max_value !== want.max_value) bad = {bad, " max_value"};
                    if (bad != "") begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: wrong%s", $time, bad);
                            $display("    expected %s", show(want));
                            $display("    actual   %s", show(i_result));
                        end
                    end
                end
            end

            if (start && !busy) begin
                case (i_cmd.op)
                    OP_ENQ: begin
                        e.idx = i_cmd.entry_index;
                        e.val = i_cmd.entry_value;
                        st = insert_entry(e);
                    end
                    OP_DEQ: st = remove_min();
                    OP_CLR: begin
                        kept_n = 0;
                        st = ST_OK;
                    end
                    default: st = ST_OK;
                endcase
                queue_views.push_back(queue_view(st));
            end
        end
        o_fail_count <= fails;
        o_pending    <= queue_views.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the bounded sorted priority queue: clock, reset, stimulus and verdict.
module tb_top;
    import bspq_pkg::*;

    localparam int  CYCLE_LIMIT     = 200000;
    localparam int  RAND_PHASES     = 14;
    localparam int  ITEMS_PER_PHASE = 125;
    localparam t_op OP_NOP          = t_op'(2'd3);

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_in               i_cmd;
    logic              o_done;
    t_out              o_result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    int                cycle_count;
    logic              idle_on;

    bounded_sorted_priority_queue_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bspq_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_done       (o_done),
        .i_result     (o_result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic t_in cmd_of(input t_op op, input logic [IDX_W-1:0] idx,
                                   input logic [VAL_W-1:0] val);
        t_in c;
        c.op          = op;
        c.entry_index = idx;
        c.entry_value = val;
        return c;
    endfunction

    function automatic t_in rand_cmd(input int unsigned enq_pct);
        int unsigned      r;
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        r = $urandom_range(0, 99);
        if (r < enq_pct)          op = OP_ENQ;
        else if (r < enq_pct + 3) op = OP_CLR;
        else if (r < enq_pct + 6) op = OP_NOP;
        else                      op = OP_DEQ;
        idx = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 3))
                                          : IDX_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 7))
            0:       val = ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            1, 2:    val = VAL_W'($urandom_range(0, 6)) - 32'd3;
            default: val = $urandom;
        endcase
        return cmd_of(op, idx, val);
    endfunction

    function automatic int unsigned pick_capacity();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 16;
            2:       return $urandom_range(17, 31);
            3, 4, 5: return $urandom_range(1, 4);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    task automatic send(input t_in c);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_max_entries(input int unsigned v);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MAX_ENTRIES;
        pwdata  <= APB_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int unsigned enq_pct;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        idle_on  = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue, extremes, ties
        send(cmd_of(OP_DEQ, 16'd0, 32'd0));
        send(cmd_of(OP_NOP, 16'hFFFF, 32'hFFFF_FFFF));
        send(cmd_of(OP_CLR, 16'd0, 32'd0));
        send(cmd_of(OP_ENQ, 16'hFFFF, 32'h7FFF_FFFF));
        send(cmd_of(OP_ENQ, 16'd0, 32'h8000_0000));
        send(cmd_of(OP_ENQ, 16'd7, 32'd0));
        send(cmd_of(OP_ENQ, 16'd7, 32'd0));
        send(cmd_of(OP_ENQ, 16'd2, 32'd0));
        send(cmd_of(OP_NOP, 16'd0, 32'd0));
        send(cmd_of(OP_DEQ, 16'd0, 32'd0));
        send(cmd_of(OP_CLR, 16'd0, 32'd0));

        // full queue: equal to max, above max, below max
        write_max_entries(2);
        send(cmd_of(OP_ENQ, 16'd1, 32'd100));
        send(cmd_of(OP_ENQ, 16'd2, -32'sd100));
        send(cmd_of(OP_ENQ, 16'd1, 32'd100));
        send(cmd_of(OP_ENQ, 16'd0, 32'd200));
        send(cmd_of(OP_ENQ, 16'd0, 32'd100));

        // capacity below count
        write_max_entries(1);
        send(cmd_of(OP_ENQ, 16'd9, 32'h7FFF_FFFF));
        send(cmd_of(OP_ENQ, 16'd9, -32'sd200));
        send(cmd_of(OP_DEQ, 16'd0, 32'd0));

        // zero capacity
        write_max_entries(0);
        send(cmd_of(OP_ENQ, 16'd3, 32'd5));
        send(cmd_of(OP_DEQ, 16'd0, 32'd0));
        send(cmd_of(OP_DEQ, 16'd0, 32'd0));
        send(cmd_of(OP_ENQ, 16'd3, 32'd5));

        // capacity above depth saturates
        write_max_entries(31);
        send(cmd_of(OP_ENQ, 16'hFFFF, 32'hFFFF_FFFF));
        send(cmd_of(OP_CLR, 16'd0, 32'd0));

        for (int p = 0; p < RAND_PHASES; p++) begin
            write_max_entries((p == 0) ? 16 : pick_capacity());
            enq_pct = $urandom_range(40, 75);
            idle_on = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            repeat (ITEMS_PER_PHASE) send(rand_cmd(enq_pct));
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
